### rtl/q2e_pkg.sv
package q2e_pkg;

	localparam int PROD_W   = 32;
	localparam int TERM_W   = 36;
	localparam int CORDIC_W = 38;
	localparam int ANG_W    = 26;
	localparam int UNIT_W   = ANG_W - 9;
	localparam int RAD_W    = 62;
	localparam int ROOT_W   = 31;
	localparam int SQ_STEPS = 31;
	localparam int TAB_LEN  = 24;

	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [TERM_W-1:0]   term_t;
	typedef logic signed [CORDIC_W-1:0] cordic_t;
	typedef logic signed [ANG_W-1:0]    ang_t;
	typedef logic signed [UNIT_W-1:0]   unit_t;
	typedef logic        [RAD_W-1:0]    rad_t;

	localparam term_t TERM_ONE   = term_t'(64'sd1 <<< 30);
	localparam ang_t  DEG90      = ang_t'(5898240);
	localparam unit_t LIM_WIDE   = unit_t'(23040);
	localparam unit_t LIM_PITCH  = unit_t'(11520);
	localparam rad_t  RAD_ONE    = rad_t'(64'd1 << 60);

	localparam ang_t ATAN_TAB [0:TAB_LEN-1] = '{
		ang_t'(2949120), ang_t'(1740967), ang_t'(919879), ang_t'(466945),
		ang_t'(234379),  ang_t'(117304),  ang_t'(58666),  ang_t'(29335),
		ang_t'(14668),   ang_t'(7334),    ang_t'(3667),   ang_t'(1833),
		ang_t'(917),     ang_t'(458),     ang_t'(229),    ang_t'(115),
		ang_t'(57),      ang_t'(29),      ang_t'(14),     ang_t'(7),
		ang_t'(4),       ang_t'(2),       ang_t'(1),      ang_t'(0)
	};

	function automatic unit_t to_units(input ang_t a, input unit_t lim);
		ang_t  sum;
		unit_t r;
		sum = a + ang_t'(256);
		r = unit_t'(sum >>> 9);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

endpackage

### rtl/quaternion_to_euler_angles.sv
// Quaternion (x, y, z, w in signed Q1.(COMPONENT_BITS-1)) to yaw, negated pitch and roll in
// 1/128 degree, with pitch_clamped set when the pitch term reaches one and pitch is forced to
// +-90 degrees. One beat is taken every cycle while the output is not stalled; the pipeline
// depth is set by the 31-stage square root of the pitch path followed by its CORDIC.
// Yaw and roll run their CORDICs early and wait in delay lines. A stall on the output freezes
// the whole pipeline, so the input stall follows it in the same cycle while a result is held.
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS   = 16,
	parameter int COMPONENT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             quat_valid,
	output logic                             quat_stall,
	input  logic signed [COMPONENT_BITS-1:0] quat_x,
	input  logic signed [COMPONENT_BITS-1:0] quat_y,
	input  logic signed [COMPONENT_BITS-1:0] quat_z,
	input  logic signed [COMPONENT_BITS-1:0] quat_w,
	output logic                             angle_valid,
	input  logic                             angle_stall,
	output logic signed [15:0]               yaw_angle,
	output logic signed [14:0]               neg_pitch_angle,
	output logic signed [15:0]               roll_angle,
	output logic                             pitch_clamped
);
	import q2e_pkg::*;

	localparam int CB    = COMPONENT_BITS;
	localparam int SH    = 2 * (CB - 1) - 30;
	localparam int SHR   = (SH > 0) ? SH : 0;
	localparam int SHL   = (SH < 0) ? -SH : 0;
	localparam int DL    = SQ_STEPS + 2;
	localparam int FL    = DL + CORDIC_STEPS;
	localparam int DEPTH = SQ_STEPS + 6 + CORDIC_STEPS;

	function automatic prod_t mul_q30(input logic signed [CB-1:0] a,
			input logic signed [CB-1:0] b);
		logic signed [2*CB+31:0] p;
		p = a * b;
		return prod_t'((p >>> SHR) <<< SHL);
	endfunction

	logic [DEPTH:1] vld_q;
	logic           adv;
	logic           acc;

	assign adv        = !vld_q[DEPTH] || !angle_stall;
	assign acc        = quat_valid && adv;
	assign quat_stall = !adv;
	assign angle_valid = vld_q[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-1:1], acc};
		end
	end

	prod_t p_xx_s1, p_yy_s1, p_zz_s1, p_wx_s1, p_yz_s1, p_wy_s1, p_zx_s1, p_wz_s1, p_xy_s1;
	term_t sin_r_s2, cos_r_s2, sin_y_s2, cos_y_s2, s_s2;
	term_t s_abs;
	logic         clamp_s3, neg_s3;
	logic [29:0]  mag_s3;
	logic [31:0]  s_s3;
	logic [59:0]  msq;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_xx_s1 <= mul_q30(quat_x, quat_x);
			p_yy_s1 <= mul_q30(quat_y, quat_y);
			p_zz_s1 <= mul_q30(quat_z, quat_z);
			p_wx_s1 <= mul_q30(quat_w, quat_x);
			p_yz_s1 <= mul_q30(quat_y, quat_z);
			p_wy_s1 <= mul_q30(quat_w, quat_y);
			p_zx_s1 <= mul_q30(quat_z, quat_x);
			p_wz_s1 <= mul_q30(quat_w, quat_z);
			p_xy_s1 <= mul_q30(quat_x, quat_y);

			sin_r_s2 <= (term_t'(p_wx_s1) + term_t'(p_yz_s1)) <<< 1;
			cos_r_s2 <= TERM_ONE - ((term_t'(p_xx_s1) + term_t'(p_yy_s1)) <<< 1);
			s_s2     <= (term_t'(p_wy_s1) - term_t'(p_zx_s1)) <<< 1;
			sin_y_s2 <= (term_t'(p_wz_s1) + term_t'(p_xy_s1)) <<< 1;
			cos_y_s2 <= TERM_ONE - ((term_t'(p_yy_s1) + term_t'(p_zz_s1)) <<< 1);

			clamp_s3 <= (s_s2 >= TERM_ONE) || (s_s2 <= -TERM_ONE);
			neg_s3   <= s_s2[TERM_W-1];
			mag_s3   <= s_abs[29:0];
			s_s3     <= s_s2[31:0];
		end
	end

	assign s_abs = s_s2[TERM_W-1] ? -s_s2 : s_s2;
	assign msq   = mag_s3 * mag_s3;

	rad_t        sq_v_s5 [0:SQ_STEPS];
	rad_t        sq_r_s5 [0:SQ_STEPS];
	logic [31:0] sq_s_s5 [0:SQ_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_v_s5[0] <= RAD_ONE - rad_t'(msq);
			sq_r_s5[0] <= '0;
			sq_s_s5[0] <= s_s3;
		end
	end

	for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
		localparam rad_t BIT = rad_t'(64'd1 << (2 * (SQ_STEPS - j)));
		rad_t trial;
		assign trial = sq_r_s5[j-1] + BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s_s5[j] <= sq_s_s5[j-1];
				if (sq_v_s5[j-1] >= trial) begin
					sq_v_s5[j] <= sq_v_s5[j-1] - trial;
					sq_r_s5[j] <= (sq_r_s5[j-1] >> 1) + BIT;
				end else begin
					sq_v_s5[j] <= sq_v_s5[j-1];
					sq_r_s5[j] <= sq_r_s5[j-1] >> 1;
				end
			end
		end
	end

	logic [ROOT_W-1:0] root;
	ang_t yaw_ang, roll_ang, pitch_ang;

	assign root = sq_r_s5[SQ_STEPS][ROOT_W-1:0];

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk  (clk),
		.en   (adv),
		.x_in (cordic_t'(cos_y_s2)),
		.y_in (cordic_t'(sin_y_s2)),
		.ang  (yaw_ang)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk  (clk),
		.en   (adv),
		.x_in (cordic_t'(cos_r_s2)),
		.y_in (cordic_t'(sin_r_s2)),
		.ang  (roll_ang)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk  (clk),
		.en   (adv),
		.x_in (cordic_t'(root)),
		.y_in (cordic_t'($signed(sq_s_s5[SQ_STEPS]))),
		.ang  (pitch_ang)
	);

	ang_t yaw_s6   [0:DL-1];
	ang_t roll_s6  [0:DL-1];
	logic clamp_s6 [0:FL-1];
	logic neg_s6   [0:FL-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_s6[0]   <= yaw_ang;
			roll_s6[0]  <= roll_ang;
			clamp_s6[0] <= clamp_s3;
			neg_s6[0]   <= neg_s3;
			for (int k = 1; k < DL; k++) begin
				yaw_s6[k]  <= yaw_s6[k-1];
				roll_s6[k] <= roll_s6[k-1];
			end
			for (int k = 1; k < FL; k++) begin
				clamp_s6[k] <= clamp_s6[k-1];
				neg_s6[k]   <= neg_s6[k-1];
			end
		end
	end

	unit_t yaw_u, roll_u, pitch_u;

	always_comb begin
		yaw_u  = to_units(yaw_s6[DL-1], LIM_WIDE);
		roll_u = to_units(roll_s6[DL-1], LIM_WIDE);
		if (clamp_s6[FL-1]) begin
			pitch_u = neg_s6[FL-1] ? -LIM_PITCH : LIM_PITCH;
		end else begin
			pitch_u = to_units(pitch_ang, LIM_PITCH);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_angle       <= yaw_u[15:0];
			roll_angle      <= roll_u[15:0];
			neg_pitch_angle <= 15'(-pitch_u);
			pitch_clamped   <= clamp_s6[FL-1];
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during stall");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> vld_q[1])
		else $error("accepted beat lost at entry");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && pitch_clamped |->
		(neg_pitch_angle == 15'sd11520 || neg_pitch_angle == -15'sd11520))
		else $error("clamped pitch not at 90 degrees");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> (yaw_angle <= 16'sd23040 && yaw_angle >= -16'sd23040 &&
		roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040))
		else $error("angle out of range");
`endif

endmodule

### rtl/q2e_cordic.sv
module q2e_cordic #(
	parameter int STEPS = 16
) (
	input  logic             clk,
	input  logic             en,
	input  q2e_pkg::cordic_t x_in,
	input  q2e_pkg::cordic_t y_in,
	output q2e_pkg::ang_t    ang
);
	import q2e_pkg::*;

	cordic_t x_s    [0:STEPS];
	cordic_t y_s    [0:STEPS];
	ang_t    a_s    [0:STEPS];
	logic    zero_s [0:STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (!x_in[CORDIC_W-1]) begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				a_s[0] <= '0;
			end else if (!y_in[CORDIC_W-1]) begin
				x_s[0] <= y_in;
				y_s[0] <= -x_in;
				a_s[0] <= DEG90;
			end else begin
				x_s[0] <= -y_in;
				y_s[0] <= x_in;
				a_s[0] <= -DEG90;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	assign ang = zero_s[STEPS] ? '0 : a_s[STEPS];

endmodule
